[rtl/point_in_polygon_ray_cast_defines.svh]
// assertion macros used by the checker file
`ifndef POINT_IN_POLYGON_RAY_CAST_DEFINES_SVH
`define POINT_IN_POLYGON_RAY_CAST_DEFINES_SVH

// property checked outside reset
`define PIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every edge, reset included
`define PIP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/pip_pkg.sv]
package pip_pkg;

    localparam int COORD_W     = 16;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int IDX_W       = 6;
    localparam int VCOUNT_W    = 7;
    localparam int TDATA_IN_W  = 40;
    localparam int TUSER_IN_W  = 1;
    localparam int TDATA_OUT_W = 8;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int WORD_W      = 2 * COORD_W;

    localparam logic CMD_VERTEX = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_VERTEX_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EXTREME_X    = 1'd1;

    localparam logic signed [COORD_W-1:0] EXTREME_X_RESET = 16'sh7fff;

    // stored vertex word: x in the low half, y in the high half
    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } vertex_t;

    typedef enum logic [1:0] {
        TURN_COL,
        TURN_CW,
        TURN_CCW
    } turn_t;

    function automatic turn_t turn_code(input logic signed [CROSS_W-1:0] v);
        turn_t t;
        if (v == '0)
            t = TURN_COL;
        else if (!v[CROSS_W-1])
            t = TURN_CW;
        else
            t = TURN_CCW;
        return t;
    endfunction

    // orientation whose cross product is -(u * v), taken from signs alone
    function automatic turn_t turn_neg_prod(input logic signed [DIFF_W-1:0] u,
                                            input logic signed [DIFF_W-1:0] v);
        turn_t t;
        if (u == '0 || v == '0)
            t = TURN_COL;
        else if (u[DIFF_W-1] != v[DIFF_W-1])
            t = TURN_CW;
        else
            t = TURN_CCW;
        return t;
    endfunction

    // q within the bounding box of segment a-b
    function automatic logic in_box(input logic signed [COORD_W-1:0] ax,
                                    input logic signed [COORD_W-1:0] ay,
                                    input logic signed [COORD_W-1:0] bx,
                                    input logic signed [COORD_W-1:0] by,
                                    input logic signed [COORD_W-1:0] qx,
                                    input logic signed [COORD_W-1:0] qy);
        logic x_ok;
        logic y_ok;
        x_ok = (ax > bx) ? (qx <= ax && qx >= bx) : (qx <= bx && qx >= ax);
        y_ok = (ay > by) ? (qy <= ay && qy >= by) : (qy <= by && qy >= ay);
        return x_ok && y_ok;
    endfunction

endpackage

[rtl/point_in_polygon_ray_cast.sv]
// Point-in-polygon test by horizontal ray casting over a vertex RAM of MAX_VERTICES
// entries. An input item with tuser 0 stores one vertex (slots at or above MAX_VERTICES
// are dropped) and gives no result; an item with tuser 1 queries a point and gives one
// result, inside_res, which is 1 for a point inside or on the boundary. The ray runs from
// the point to (extreme_x, point y). vertex_count above MAX_VERTICES counts as
// MAX_VERTICES; with fewer than two vertices the answer is 1, with two it is the
// bounding-box test of the point against that segment. Vertex RAM contents are undefined
// after reset and there is no clearing pass: only written slots may be used. For n of three
// or more vertices the single RAM read port walks one vertex per cycle (n reads plus a
// reread of vertex 0 to close the polygon), then come the two pipeline stages, the drain
// state latches the result and the finish state presents it. With two vertices the walk
// reads just those two, and with fewer than two the query goes straight to the finish
// state. The input is ready again in the cycle the result appears. One query is in flight
// at a time; the result waits in an output register and a finished query enters that
// register only once it is free, so an output stall holds the query in its finish state.
module point_in_polygon_ray_cast #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // vertex_index [5:0], coord_x [21:6], coord_y [37:22], zero fill
    input  logic [pip_pkg::TDATA_IN_W-1:0]     s_tdata,
    // command
    input  logic [pip_pkg::TUSER_IN_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // inside_res [0], zero fill
    output logic [pip_pkg::TDATA_OUT_W-1:0]    m_tdata,
    input  logic                               cfg_we,
    input  logic [pip_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pip_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import pip_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int CW = (NW > VCOUNT_W) ? NW : VCOUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // configuration
    logic [VCOUNT_W-1:0]       vcount_reg;
    logic signed [COORD_W-1:0] extreme_x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= '0;
            extreme_x_reg <= EXTREME_X_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_VERTEX_COUNT: vcount_reg    <= cfg_wdata[VCOUNT_W-1:0];
                REG_EXTREME_X:    extreme_x_reg <= $signed(cfg_wdata[COORD_W-1:0]);
            endcase
        end
    end

    // input item
    logic                      in_cmd;
    logic [IDX_W-1:0]          in_idx;
    logic [COORD_W-1:0]        in_x;
    logic [COORD_W-1:0]        in_y;
    logic                      in_acc;
    logic                      q_start;
    logic                      v_write;

    assign in_cmd  = s_tuser[0];
    assign in_idx  = s_tdata[IDX_W-1:0];
    assign in_x    = s_tdata[IDX_W+COORD_W-1:IDX_W];
    assign in_y    = s_tdata[IDX_W+2*COORD_W-1:IDX_W+COORD_W];
    assign in_acc  = s_tvalid && s_tready;
    assign q_start = in_acc && (in_cmd == CMD_QUERY);
    assign v_write = in_acc && (in_cmd == CMD_VERTEX)
                     && (32'(in_idx) < 32'(MAX_VERTICES));

    logic [CW-1:0] vc_ext;
    logic [NW-1:0] n_sat;

    assign vc_ext = CW'(vcount_reg);
    assign n_sat  = (vc_ext > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vc_ext[NW-1:0];

    // control
    state_t                    state_reg;
    logic [NW-1:0]             n_reg;
    logic [NW-1:0]             k_reg;
    logic [NW-1:0]             last_k_reg;
    logic                      two_reg;
    logic                      res_reg;
    logic                      m_tvalid_reg;
    logic                      m_res_reg;
    logic signed [COORD_W-1:0] px_reg;
    logic signed [COORD_W-1:0] py_reg;
    logic                      fin;
    logic                      fin_res;

    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [WORD_W-1:0]         rd_data;

    assign rd_en   = (state_reg == ST_ISSUE);
    // after the last vertex the walk rereads vertex 0 to close the polygon
    assign rd_addr = (k_reg < n_reg) ? k_reg[AW-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            n_reg        <= '0;
            k_reg        <= '0;
            last_k_reg   <= '0;
            two_reg      <= 1'b0;
            res_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_res_reg    <= 1'b0;
        end
        else
        begin
            // the finish state loads the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_start)
                    begin
                        n_reg   <= n_sat;
                        k_reg   <= '0;
                        two_reg <= (n_sat == NW'(2));
                        last_k_reg <= (n_sat == NW'(2)) ? NW'(1) : n_sat;
                        if (n_sat < NW'(2))
                        begin
                            res_reg   <= 1'b1;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE:
                begin
                    k_reg <= k_reg + NW'(1);
                    if (k_reg == last_k_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (fin)
                    begin
                        res_reg   <= fin_res;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_res_reg    <= res_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_start)
        begin
            px_reg <= $signed(in_x);
            py_reg <= $signed(in_y);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(TDATA_OUT_W-1)'(0), m_res_reg};

    // vertex store; writes only happen while idle, so reads never meet a write
    pip_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (v_write),
        .waddr (AW'(in_idx)),
        .wdata ({in_y, in_x}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // read tags, aligned with rd_data
    logic    q_vld_reg;
    logic    q_first_reg;
    logic    q_last_reg;
    vertex_t prev_reg;
    vertex_t cur_v;

    assign cur_v = vertex_t'(rd_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg   <= 1'b0;
            q_first_reg <= 1'b0;
            q_last_reg  <= 1'b0;
        end
        else
        begin
            q_vld_reg   <= rd_en;
            q_first_reg <= (k_reg == '0);
            q_last_reg  <= (k_reg == last_k_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_vld_reg)
        begin
            prev_reg <= cur_v;
        end
    end

    // stage 1: edge a-b differences, sign-only turns against the ray, box tests
    logic signed [COORD_W-1:0] ax, ay, bx, by;
    logic                      e_vld;

    assign ax    = $signed(prev_reg.x);
    assign ay    = $signed(prev_reg.y);
    assign bx    = $signed(cur_v.x);
    assign by    = $signed(cur_v.y);
    assign e_vld = q_vld_reg && !q_first_reg;

    logic                      e1_vld_reg, e1_last_reg;
    logic signed [DIFF_W-1:0]  e1_dyab_reg, e1_dxab_reg, e1_pxb_reg, e1_exb_reg, e1_pyb_reg;
    turn_t                     e1_t3_reg, e1_t4_reg;
    logic                      e1_pbox_reg, e1_fbox_reg, e1_abox_reg, e1_bbox_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_vld_reg  <= 1'b0;
            e1_last_reg <= 1'b0;
        end
        else
        begin
            e1_vld_reg  <= e_vld;
            e1_last_reg <= q_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_dyab_reg <= DIFF_W'(by) - DIFF_W'(ay);
        e1_dxab_reg <= DIFF_W'(bx) - DIFF_W'(ax);
        e1_pxb_reg  <= DIFF_W'(px_reg) - DIFF_W'(bx);
        e1_exb_reg  <= DIFF_W'(extreme_x_reg) - DIFF_W'(bx);
        e1_pyb_reg  <= DIFF_W'(py_reg) - DIFF_W'(by);
        // the ray is horizontal, so its cross products reduce to one signed product
        e1_t3_reg   <= turn_neg_prod(DIFF_W'(extreme_x_reg) - DIFF_W'(px_reg),
                                     DIFF_W'(ay) - DIFF_W'(py_reg));
        e1_t4_reg   <= turn_neg_prod(DIFF_W'(extreme_x_reg) - DIFF_W'(px_reg),
                                     DIFF_W'(by) - DIFF_W'(py_reg));
        e1_pbox_reg <= in_box(ax, ay, bx, by, px_reg, py_reg);
        e1_fbox_reg <= in_box(ax, ay, bx, by, extreme_x_reg, py_reg);
        e1_abox_reg <= in_box(px_reg, py_reg, extreme_x_reg, py_reg, ax, ay);
        e1_bbox_reg <= in_box(px_reg, py_reg, extreme_x_reg, py_reg, bx, by);
    end

    // stage 2: products that make up the edge-side cross products behind t1 and t2
    logic                      e2_vld_reg, e2_last_reg;
    logic signed [PROD_W-1:0]  e2_m0_reg, e2_m1_reg, e2_m2_reg;
    turn_t                     e2_t3_reg, e2_t4_reg;
    logic                      e2_pbox_reg, e2_fbox_reg, e2_abox_reg, e2_bbox_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e2_vld_reg  <= 1'b0;
            e2_last_reg <= 1'b0;
        end
        else
        begin
            e2_vld_reg  <= e1_vld_reg;
            e2_last_reg <= e1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e2_m0_reg   <= e1_dyab_reg * e1_pxb_reg;
        e2_m1_reg   <= e1_dyab_reg * e1_exb_reg;
        e2_m2_reg   <= e1_dxab_reg * e1_pyb_reg;
        e2_t3_reg   <= e1_t3_reg;
        e2_t4_reg   <= e1_t4_reg;
        e2_pbox_reg <= e1_pbox_reg;
        e2_fbox_reg <= e1_fbox_reg;
        e2_abox_reg <= e1_abox_reg;
        e2_bbox_reg <= e1_bbox_reg;
    end

    // stage 3: orientation of the point and the ray end against the edge, then count
    turn_t t1, t2;
    logic  meet;
    logic  coll;
    logic  parity_reg;
    logic  dec_reg;
    logic  dec_val_reg;

    assign t1 = turn_code(CROSS_W'(e2_m0_reg) - CROSS_W'(e2_m2_reg));
    assign t2 = turn_code(CROSS_W'(e2_m1_reg) - CROSS_W'(e2_m2_reg));

    assign meet = (t1 != t2 && e2_t3_reg != e2_t4_reg)
                  || (t1 == TURN_COL && e2_pbox_reg)
                  || (t2 == TURN_COL && e2_fbox_reg)
                  || (e2_t3_reg == TURN_COL && e2_abox_reg)
                  || (e2_t4_reg == TURN_COL && e2_bbox_reg);
    // crossed edge through the point: first such edge decides by its box
    assign coll = meet && (t1 == TURN_COL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg  <= 1'b0;
            dec_reg     <= 1'b0;
            dec_val_reg <= 1'b0;
        end
        else if (q_start)
        begin
            parity_reg <= 1'b0;
            dec_reg    <= 1'b0;
        end
        else if (e2_vld_reg && !dec_reg && meet)
        begin
            if (coll)
            begin
                dec_reg     <= 1'b1;
                dec_val_reg <= e2_pbox_reg;
            end
            else
            begin
                parity_reg <= !parity_reg;
            end
        end
    end

    assign fin = e2_vld_reg && e2_last_reg;

    always_comb
    begin
        priority if (two_reg)
            fin_res = e2_pbox_reg;
        else if (dec_reg)
            fin_res = dec_val_reg;
        else if (coll)
            fin_res = e2_pbox_reg;
        else
            fin_res = parity_reg ^ meet;
    end

endmodule

[rtl/pip_ram.sv]
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/pip_checker.sv]
`include "point_in_polygon_ray_cast_defines.svh"

module pip_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [pip_pkg::TUSER_IN_W-1:0]     s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [pip_pkg::TDATA_OUT_W-1:0]    m_tdata
);

    import pip_pkg::*;

    // a stalled result holds
    `PIP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // a query blocks further items while it runs
    `PIP_ASSERT(a_query_busy, s_tvalid && s_tready && s_tuser[0] == CMD_QUERY |=> !s_tready, "item taken during a query")

    // a vertex write never produces a result
    `PIP_ASSERT(a_vertex_silent, s_tvalid && s_tready && s_tuser[0] == CMD_VERTEX && !m_tvalid |=> !m_tvalid, "result after a vertex write")

    // an edge seen in reset clears the result
    `PIP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid, "result valid in reset")

endmodule

bind point_in_polygon_ray_cast pip_checker u_pip_checker (.*);

[tb/tb_point_in_polygon_ray_cast.sv]
`timescale 1ns / 100ps

module tb_point_in_polygon_ray_cast;

    import pip_pkg::*;

    localparam int NUM_SLOTS     = 64;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEM_TARGET   = 750;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct {
        longint x;
        longint y;
    } pt_t;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] wdata;
        logic                  cmd;
        logic [IDX_W-1:0]      idx;
        coord_t                x;
        coord_t                y;
        logic                  typed;
        logic                  res;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // vertex_index [5:0], coord_x [21:6], coord_y [37:22], zero fill
    logic [TDATA_IN_W-1:0]  s_tdata;
    // command
    logic [TUSER_IN_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // inside_res [0], zero fill
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // shadow of the block's vertex table and registers
    coord_t              poly_x [NUM_SLOTS];
    coord_t              poly_y [NUM_SLOTS];
    logic [VCOUNT_W-1:0] vcount_sh;
    coord_t              far_x_sh;

    logic inside_q [$];
    logic want_inside;
    int   fail_cnt      = 0;
    int   items_sent    = 0;
    int   stall_cycles  = 0;
    int   tx_idle_pct   = 7;
    int   rx_idle_pct   = 48;
    bit   hold_req      = 1'b0;
    bit   pressure_done = 1'b0;

    point_in_polygon_ray_cast #(
        .MAX_VERTICES (NUM_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // ---------------- inside/outside predictor ----------------

    function automatic turn_t orient(pt_t a, pt_t b, pt_t c);
        longint v;
        v = (b.y - a.y) * (c.x - b.x) - (b.x - a.x) * (c.y - b.y);
        if (v == 0)
            return TURN_COL;
        return (v > 0) ? TURN_CW : TURN_CCW;
    endfunction

    // q within the bounding box of a-b
    function automatic logic in_bbox(pt_t a, pt_t b, pt_t q);
        return q.x <= ((a.x > b.x) ? a.x : b.x) && q.x >= ((a.x < b.x) ? a.x : b.x) &&
               q.y <= ((a.y > b.y) ? a.y : b.y) && q.y >= ((a.y < b.y) ? a.y : b.y);
    endfunction

    function automatic logic edges_meet(pt_t a1, pt_t b1, pt_t a2, pt_t b2);
        turn_t t1;
        turn_t t2;
        turn_t t3;
        turn_t t4;
        t1 = orient(a1, b1, a2);
        t2 = orient(a1, b1, b2);
        t3 = orient(a2, b2, a1);
        t4 = orient(a2, b2, b1);
        if (t1 != t2 && t3 != t4)
            return 1'b1;
        return (t1 == TURN_COL && in_bbox(a1, b1, a2)) ||
               (t2 == TURN_COL && in_bbox(a1, b1, b2)) ||
               (t3 == TURN_COL && in_bbox(a2, b2, a1)) ||
               (t4 == TURN_COL && in_bbox(a2, b2, b1));
    endfunction

    function automatic pt_t slot_pt(int i);
        pt_t r;
        r.x = poly_x[i];
        r.y = poly_y[i];
        return r;
    endfunction

    function automatic logic predict_inside(coord_t px, coord_t py);
        int  n;
        int  j;
        int  crossings;
        pt_t p;
        pt_t far_end;
        pt_t a;
        pt_t b;
        n = (vcount_sh > NUM_SLOTS) ? NUM_SLOTS : int'(vcount_sh);
        p.x = px;
        p.y = py;
        if (n < 2)
            return 1'b1;
        if (n == 2)
            return in_bbox(slot_pt(0), slot_pt(1), p);
        far_end.x = far_x_sh;
        far_end.y = py;
        crossings = 0;
        for (int i = 0; i < n; i++)
        begin
            j = (i + 1 == n) ? 0 : i + 1;
            a = slot_pt(i);
            b = slot_pt(j);
            if (edges_meet(a, b, p, far_end))
            begin
                // point on the line of a crossed edge: that edge alone decides
                if (orient(a, p, b) == TURN_COL)
                    return in_bbox(a, b, p);
                crossings++;
            end
        end
        return crossings[0];
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic coord_t sat16(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return coord_t'(v);
    endfunction

    function automatic coord_t rand_near(int c, int r);
        return sat16(c + int'($urandom_range(0, 2 * r)) - r);
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_ADDR_W-1:0] addr,
                                         logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r = '0;
        r.kind  = ROW_CFG;
        r.addr  = addr;
        r.wdata = val;
        return r;
    endfunction

    function automatic dir_row_t vtx_row(logic [IDX_W-1:0] idx, coord_t x, coord_t y);
        dir_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.cmd  = CMD_VERTEX;
        r.idx  = idx;
        r.x    = x;
        r.y    = y;
        return r;
    endfunction

    function automatic dir_row_t qry_row(coord_t x, coord_t y);
        dir_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.cmd  = CMD_QUERY;
        r.x    = x;
        r.y    = y;
        return r;
    endfunction

    function automatic dir_row_t qry_typed(coord_t x, coord_t y, logic res);
        dir_row_t r;
        r = qry_row(x, y);
        r.typed = 1'b1;
        r.res   = res;
        return r;
    endfunction

    task automatic push_item(logic cmd, logic [IDX_W-1:0] idx, coord_t x, coord_t y,
                             logic typed = 1'b0, logic res = 1'b0);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= TDATA_IN_W'({y, x, idx});
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (cmd == CMD_VERTEX)
        begin
            poly_x[idx] = x;
            poly_y[idx] = y;
        end
        else
            inside_q.insert(inside_q.size(), typed ? res : predict_inside(x, y));
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == REG_VERTEX_COUNT)
            vcount_sh = val[VCOUNT_W-1:0];
        else if (addr == REG_EXTREME_X)
            far_x_sh = val;
        @(posedge clk);
    endtask

    // wait for all results, then let a trailing vertex write finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (inside_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase();
        int     n_cfg;
        int     m;
        int     mm;
        int     nq;
        int     r;
        int     cx;
        int     cy;
        int     w;
        int     h;
        int     k;
        int     j;
        bit     noise;
        bit     use_rect;
        coord_t far_x;
        coord_t qx;
        coord_t qy;

        if (items_sent < ITEM_TARGET / 3)
        begin
            tx_idle_pct = 7;
            rx_idle_pct = 48;
        end
        else if (items_sent < 2 * ITEM_TARGET / 3)
        begin
            tx_idle_pct = 48;
            rx_idle_pct = 7;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end

        case ($urandom_range(0, 19))
            0:       n_cfg = $urandom_range(0, 1);
            1:       n_cfg = 2;
            2:       n_cfg = NUM_SLOTS;
            3:       n_cfg = $urandom_range(NUM_SLOTS + 1, 127);
            default: n_cfg = $urandom_range(3, 12);
        endcase
        m  = (n_cfg > NUM_SLOTS) ? NUM_SLOTS : n_cfg;
        mm = (m < 2) ? 2 : m;

        case ($urandom_range(0, 6))
            4:       far_x = 16'sh8000;
            5:       far_x = coord_t'($urandom);
            6:       far_x = rand_near(0, 100);
            default: far_x = 16'sh7fff;
        endcase

        settle();
        // upper bits of the count write are don't-care
        write_reg(REG_VERTEX_COUNT, {9'($urandom_range(0, 511)), 7'(n_cfg)});
        write_reg(REG_EXTREME_X, far_x);

        case ($urandom_range(0, 3))
            0:       r = 2;
            1:       r = 20;
            2:       r = 1000;
            default: r = 32768;
        endcase
        cx = (r == 32768) ? 0 : int'($urandom_range(0, 65535)) - 32768;
        cy = (r == 32768) ? 0 : int'($urandom_range(0, 65535)) - 32768;
        noise = ($urandom_range(0, 7) == 0);

        if (!noise)
        begin
            use_rect = (m == 4) && ($urandom_range(0, 1) == 1);
            w = $urandom_range(0, r);
            h = $urandom_range(0, r);
            for (int i = 0; i < m; i++)
            begin
                if (use_rect)
                    push_item(CMD_VERTEX, IDX_W'(i),
                              sat16((i == 0 || i == 3) ? cx - w : cx + w),
                              sat16((i < 2) ? cy - h : cy + h));
                else
                    push_item(CMD_VERTEX, IDX_W'(i), rand_near(cx, r), rand_near(cy, r));
            end
        end

        // long receiver hold-off while queries keep coming
        if (tx_idle_pct == 0 && !pressure_done)
        begin
            hold_req      = 1'b1;
            pressure_done = 1'b1;
        end

        nq = (m >= NUM_SLOTS) ? $urandom_range(3, 6) : $urandom_range(8, 24);
        for (int q = 0; q < nq; q++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_item(CMD_VERTEX, IDX_W'($urandom_range(0, 63)),
                          rand_near(cx, r), rand_near(cy, r));
            k = $urandom_range(0, mm - 1);
            j = (k + 1 == mm) ? 0 : k + 1;
            case (noise ? 6 : $urandom_range(0, 5))
                0:
                begin
                    qx = poly_x[k];
                    qy = poly_y[k];
                end
                1:
                begin
                    qx = sat16((int'(poly_x[k]) + int'(poly_x[j])) >>> 1);
                    qy = sat16((int'(poly_y[k]) + int'(poly_y[j])) >>> 1);
                end
                2:
                begin
                    // ray through a vertex height
                    qx = rand_near(cx, r + 2);
                    qy = poly_y[k];
                end
                3, 4:
                begin
                    qx = rand_near(cx, r + 2);
                    qy = rand_near(cy, r + 2);
                end
                default:
                begin
                    qx = coord_t'($urandom);
                    qy = coord_t'($urandom);
                end
            endcase
            push_item(CMD_QUERY, IDX_W'($urandom_range(0, 63)), qx, qy);
        end
    endtask

    // ---------------- main sequence ----------------

    initial
    begin
        dir_row_t dir_tab [30];

        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        vcount_sh = '0;
        far_x_sh  = EXTREME_X_RESET;

        dir_tab = '{
            qry_typed(0, 0, 1'b1),              // no vertices: inside
            qry_typed(-32768, 32767, 1'b1),
            cfg_row(REG_VERTEX_COUNT, 1),
            qry_typed(32767, -32768, 1'b1),     // one vertex: still inside
            vtx_row(0, -100, -100),
            vtx_row(1, 100, -100),
            vtx_row(2, 100, 100),
            vtx_row(3, -100, 100),
            cfg_row(REG_VERTEX_COUNT, 2),       // two vertices: segment box test
            qry_row(0, -100),
            qry_row(0, 0),
            cfg_row(REG_VERTEX_COUNT, 4),
            qry_row(0, 0),
            qry_row(200, 0),
            qry_row(100, 50),                   // on the right edge
            qry_row(0, 100),                    // ray runs along the top edge
            qry_row(-100, -100),
            qry_row(-150, 100),                 // in line with the top edge, off it
            cfg_row(REG_EXTREME_X, -32768),
            qry_row(0, 0),
            qry_row(-200, 0),
            vtx_row(0, -32768, -32768),
            vtx_row(1, 32767, -32768),
            vtx_row(2, 0, 32767),
            cfg_row(REG_VERTEX_COUNT, 3),
            cfg_row(REG_EXTREME_X, 32767),
            qry_row(32767, 32767),
            qry_row(0, 0),
            qry_row(-32768, -32768),
            qry_row(32767, -32768)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(dir_tab[i].addr, dir_tab[i].wdata);
            end
            else
                push_item(dir_tab[i].cmd, dir_tab[i].idx, dir_tab[i].x, dir_tab[i].y,
                          dir_tab[i].typed, dir_tab[i].res);
        end

        // fill every slot so any vertex count only reads written entries
        for (int i = 0; i < NUM_SLOTS; i++)
            push_item(CMD_VERTEX, IDX_W'(i), coord_t'($urandom), coord_t'($urandom));

        while (items_sent < ITEM_TARGET)
            run_phase();

        settle();
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // result side ready, with random stalls and one long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (inside_q.size() == 0)
            begin
                $error("inside_res: expected nothing, actual %0b", m_tdata[0]);
                fail_cnt++;
            end
            else
            begin
                want_inside = inside_q.pop_front();
                if (m_tdata[0] !== want_inside)
                begin
                    $error("inside_res: expected %0b, actual %0b", want_inside, m_tdata[0]);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule

[point_in_polygon_ray_cast.f]
+incdir+rtl
rtl/pip_pkg.sv
rtl/pip_ram.sv
rtl/point_in_polygon_ray_cast.sv
rtl/pip_checker.sv
tb/tb_point_in_polygon_ray_cast.sv
